// ----- rtl/dmd_pkg.sv -----
package dmd_pkg;

	localparam int DMD_MAX_RESULTS = 3;
	localparam int DMD_QUEUE_DEPTH = 4;

	localparam logic [14:0] DMD_DUTY_LIMIT_RST = 15'd32767;
	localparam logic [14:0] DMD_TILT_LIMIT_RST = 15'd20;
	localparam logic [15:0] DMD_TICKS_RST      = 16'd200;
	localparam logic [15:0] DMD_SEC_WRAP_RST   = 16'd9000;

	typedef enum logic {
		OP_MOTOR   = 1'b0,
		OP_ENCODER = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		CFG_DEAD_ZONE_LEFT   = 3'd0,
		CFG_DEAD_ZONE_RIGHT  = 3'd1,
		CFG_DUTY_LIMIT       = 3'd2,
		CFG_TILT_LIMIT       = 3'd3,
		CFG_TICKS_PER_SECOND = 3'd4,
		CFG_SECONDS_WRAP     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] left_command;
		logic signed [15:0] right_command;
		logic signed [15:0] tilt_angle;
		logic [7:0]         left_count;
		logic [7:0]         right_count;
	} in_word_t;

	typedef struct packed {
		logic [14:0]        left_forward_duty;
		logic [14:0]        left_reverse_duty;
		logic [14:0]        right_forward_duty;
		logic [14:0]        right_reverse_duty;
		logic               dead_time_hold;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic [15:0]        seconds;
		logic               last;
	} out_word_t;

	typedef struct packed {
		logic       push;
		logic [1:0] count;
	} push_ctl_t;

endpackage

// ----- rtl/dmd_shape.sv -----
module dmd_shape
	import dmd_pkg::*;
(
	input  logic signed [15:0] cmd,
	input  logic [13:0]        dead_zone,
	input  logic [14:0]        limit,
	input  logic               stop,
	output logic [14:0]        fwd,
	output logic [14:0]        rev,
	output logic               reverse
);

	logic signed [17:0] cmd_x;
	logic signed [17:0] dz_x;
	logic signed [17:0] lim_x;
	logic signed [17:0] v;
	logic signed [17:0] d;
	logic signed [17:0] neg;

	assign cmd_x = {{2{cmd[15]}}, cmd};
	assign dz_x  = {4'b0000, dead_zone};
	assign lim_x = {3'b000, limit};

	always_comb begin
		if (stop) begin
			v = '0;
		end else if (cmd > 16'sd0) begin
			v = cmd_x + dz_x;
		end else if (cmd < 16'sd0) begin
			v = cmd_x - dz_x;
		end else begin
			v = '0;
		end
		if (v > lim_x) begin
			d = lim_x;
		end else if (v < -lim_x) begin
			d = -lim_x;
		end else begin
			d = v;
		end
	end

	assign neg     = -d;
	assign reverse = d[17];
	assign fwd     = d[17] ? 15'd0 : d[15:1];
	assign rev     = d[17] ? neg[14:0] : 15'd0;

endmodule

// ----- rtl/dmd_result_queue.sv -----
module dmd_result_queue
	import dmd_pkg::*;
#(
	parameter int DEPTH = DMD_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  push_ctl_t ctl,
	input  out_word_t words [DMD_MAX_RESULTS],
	output logic      space,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int CW = $clog2(DEPTH + 1);

	out_word_t       entry_q [DEPTH];
	out_word_t       entry_n [DEPTH];
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   base;
	logic            pop;

	assign pop       = out_valid && out_ready;
	assign base      = cnt_q - CW'(pop);
	assign space     = base <= CW'(DEPTH - DMD_MAX_RESULTS);
	assign out_valid = cnt_q != '0;
	assign out_data  = entry_q[0];

	always_comb begin
		for (int i = 0; i < DEPTH - 1; i++) begin
			entry_n[i] = pop ? entry_q[i + 1] : entry_q[i];
		end
		entry_n[DEPTH - 1] = entry_q[DEPTH - 1];
		for (int i = 0; i < DEPTH; i++) begin
			if (ctl.push && i >= int'(base) && i < int'(base) + int'(ctl.count)) begin
				entry_n[i] = words[2'(i - int'(base))];
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + (ctl.push ? CW'(ctl.count) : CW'(0));
		end
	end

endmodule

// ----- rtl/dual_motor_drive_and_encoder_speed_top.sv -----
// An accepted input word waits in a stage-one register; its results then go to the
// result queue. One input word per cycle while the queue has room; a motor command
// makes one to three words; the four-entry queue pops one per out_ready cycle.
// Reset: asynchronous, active low; configuration returns to its defaults, and
// directions, duties, speed accumulators and the timer clear to zero.
module dual_motor_drive_and_encoder_speed_top
	import dmd_pkg::*;
#(
	parameter int QUEUE_DEPTH = DMD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	logic [13:0] dz_left_q;
	logic [13:0] dz_right_q;
	logic [14:0] duty_limit_q;
	logic [14:0] tilt_limit_q;
	logic [15:0] ticks_q;
	logic [15:0] sec_wrap_q;

	logic        dir_left_q;
	logic        dir_right_q;
	logic [14:0] duty_q [4];
	logic [15:0] acc_left_q;
	logic [15:0] acc_right_q;
	logic [15:0] tick_q;
	logic [15:0] sec_q;

	in_word_t    item_s1;
	logic        valid_s1;
	logic        fire_s1;
	logic        space;

	logic signed [16:0] tilt_x;
	logic [16:0] tilt_mag;
	logic        stop;
	logic [14:0] lf, lr, rf, rr;
	logic        want_l, want_r;
	logic        flip_l, flip_r;
	logic [15:0] acc_left_n, acc_right_n;
	logic [15:0] tick_inc, tick_n, sec_inc, sec_n;
	out_word_t   snap_r, snap_l, fin;
	out_word_t   words [DMD_MAX_RESULTS];
	push_ctl_t   ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_left_q    <= '0;
			dz_right_q   <= '0;
			duty_limit_q <= DMD_DUTY_LIMIT_RST;
			tilt_limit_q <= DMD_TILT_LIMIT_RST;
			ticks_q      <= DMD_TICKS_RST;
			sec_wrap_q   <= DMD_SEC_WRAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_DEAD_ZONE_LEFT:   dz_left_q    <= cfg_data[13:0];
				CFG_DEAD_ZONE_RIGHT:  dz_right_q   <= cfg_data[13:0];
				CFG_DUTY_LIMIT:       duty_limit_q <= cfg_data[14:0];
				CFG_TILT_LIMIT:       tilt_limit_q <= cfg_data[14:0];
				CFG_TICKS_PER_SECOND: ticks_q      <= cfg_data;
				CFG_SECONDS_WRAP:     sec_wrap_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fire_s1  = valid_s1 && space;
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign tilt_x   = {item_s1.tilt_angle[15], item_s1.tilt_angle};
	assign tilt_mag = tilt_x[16] ? 17'(-tilt_x) : 17'(tilt_x);
	assign stop     = tilt_mag > {2'b00, tilt_limit_q};

	dmd_shape u_shape_left (
		.cmd       (item_s1.left_command),
		.dead_zone (dz_left_q),
		.limit     (duty_limit_q),
		.stop      (stop),
		.fwd       (lf),
		.rev       (lr),
		.reverse   (want_l)
	);

	dmd_shape u_shape_right (
		.cmd       (item_s1.right_command),
		.dead_zone (dz_right_q),
		.limit     (duty_limit_q),
		.stop      (stop),
		.fwd       (rf),
		.rev       (rr),
		.reverse   (want_r)
	);

	assign flip_l = want_l != dir_left_q;
	assign flip_r = want_r != dir_right_q;

	assign acc_left_n  = dir_left_q ? acc_left_q - {8'd0, item_s1.left_count}
	                                : acc_left_q + {8'd0, item_s1.left_count};
	assign acc_right_n = dir_right_q ? acc_right_q - {8'd0, item_s1.right_count}
	                                 : acc_right_q + {8'd0, item_s1.right_count};

	assign tick_inc = tick_q + 16'd1;
	assign sec_inc  = sec_q + 16'd1;

	always_comb begin
		tick_n = tick_inc;
		sec_n  = sec_q;
		if (tick_inc >= ticks_q) begin
			tick_n = '0;
			sec_n  = (sec_inc == sec_wrap_q) ? 16'd0 : sec_inc;
		end
	end

	always_comb begin
		snap_r = '{left_forward_duty: duty_q[0], left_reverse_duty: duty_q[1],
		           right_forward_duty: 15'd0, right_reverse_duty: 15'd0,
		           dead_time_hold: 1'b1, left_speed: acc_left_q,
		           right_speed: acc_right_q, seconds: sec_q, last: 1'b0};
		snap_l = '{left_forward_duty: 15'd0, left_reverse_duty: 15'd0,
		           right_forward_duty: rf, right_reverse_duty: rr,
		           dead_time_hold: 1'b1, left_speed: acc_left_q,
		           right_speed: acc_right_q, seconds: sec_q, last: 1'b0};
		fin    = '{left_forward_duty: lf, left_reverse_duty: lr,
		           right_forward_duty: rf, right_reverse_duty: rr,
		           dead_time_hold: 1'b0, left_speed: acc_left_q,
		           right_speed: acc_right_q, seconds: sec_q, last: 1'b1};
		words[0] = fin;
		words[1] = fin;
		words[2] = fin;
		ctl.push = fire_s1;
		if (item_s1.opcode == OP_ENCODER) begin
			ctl.count = 2'd1;
			words[0] = '{left_forward_duty: duty_q[0], left_reverse_duty: duty_q[1],
			             right_forward_duty: duty_q[2], right_reverse_duty: duty_q[3],
			             dead_time_hold: 1'b0, left_speed: acc_left_n,
			             right_speed: acc_right_n, seconds: sec_n, last: 1'b1};
		end else begin
			ctl.count = 2'd1 + 2'(flip_r) + 2'(flip_l);
			if (flip_r && flip_l) begin
				words[0] = snap_r;
				words[1] = snap_l;
			end else if (flip_r) begin
				words[0] = snap_r;
			end else if (flip_l) begin
				words[0] = snap_l;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_left_q  <= 1'b0;
			dir_right_q <= 1'b0;
			duty_q      <= '{default: '0};
			acc_left_q  <= '0;
			acc_right_q <= '0;
			tick_q      <= '0;
			sec_q       <= '0;
		end else if (fire_s1) begin
			if (item_s1.opcode == OP_ENCODER) begin
				acc_left_q  <= acc_left_n;
				acc_right_q <= acc_right_n;
				tick_q      <= tick_n;
				sec_q       <= sec_n;
			end else begin
				dir_left_q  <= want_l;
				dir_right_q <= want_r;
				duty_q[0]   <= lf;
				duty_q[1]   <= lr;
				duty_q[2]   <= rf;
				duty_q[3]   <= rr;
			end
		end
	end

	dmd_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.words     (words),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import dmd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTED = 200;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	dual_motor_drive_and_encoder_speed_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [13:0] dz_left, dz_right;
	logic [14:0] duty_lim, tilt_lim;
	logic [15:0] tick_limit, sec_wrap;
	bit          motor_rev [2];
	logic [14:0] duty_reg [4];
	logic [15:0] speed_left, speed_right, tick_count, sec_count;

	out_word_t expected_drive_words [$];
	out_word_t front_word;

	int errors = 0;
	int printed = 0;
	int motor_items = 0;
	int encoder_items = 0;
	int words_checked = 0;
	int snapshots_seen = 0;
	int reg_writes = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int receiver_hold = 0;
	int ready_run_left = 0;
	int stall_pct = 0;
	int idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic reset_prediction();
		dz_left = '0;
		dz_right = '0;
		duty_lim = DMD_DUTY_LIMIT_RST;
		tilt_lim = DMD_TILT_LIMIT_RST;
		tick_limit = DMD_TICKS_RST;
		sec_wrap = DMD_SEC_WRAP_RST;
		motor_rev[0] = 1'b0;
		motor_rev[1] = 1'b0;
		for (int i = 0; i < 4; i++) duty_reg[i] = '0;
		speed_left = '0;
		speed_right = '0;
		tick_count = '0;
		sec_count = '0;
	endtask

	task automatic apply_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			CFG_DEAD_ZONE_LEFT:   dz_left = val[13:0];
			CFG_DEAD_ZONE_RIGHT:  dz_right = val[13:0];
			CFG_DUTY_LIMIT:       duty_lim = val[14:0];
			CFG_TILT_LIMIT:       tilt_lim = val[14:0];
			CFG_TICKS_PER_SECOND: tick_limit = val;
			CFG_SECONDS_WRAP:     sec_wrap = val;
			default: ;
		endcase
	endtask

	function automatic int shaped_duty(logic signed [15:0] cmd, logic [13:0] dz, bit stop);
		int v;
		int lim;
		v = cmd;
		lim = int'(duty_lim);
		if (v > 0) v = v + int'(dz);
		else if (v < 0) v = v - int'(dz);
		if (stop) v = 0;
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v;
	endfunction

	task automatic push_word(bit hold, bit fin);
		out_word_t w;
		w.left_forward_duty = duty_reg[0];
		w.left_reverse_duty = duty_reg[1];
		w.right_forward_duty = duty_reg[2];
		w.right_reverse_duty = duty_reg[3];
		w.dead_time_hold = hold;
		w.left_speed = speed_left;
		w.right_speed = speed_right;
		w.seconds = sec_count;
		w.last = fin;
		expected_drive_words.push_back(w);
	endtask

	task automatic drive_side(int side, int d);
		bit want;
		int base;
		want = (d < 0);
		base = side * 2;
		if (want != motor_rev[side]) begin
			duty_reg[base] = '0;
			duty_reg[base + 1] = '0;
			push_word(1'b1, 1'b0);
		end
		if (d >= 0) begin
			duty_reg[base] = 15'(d / 2);
			duty_reg[base + 1] = '0;
		end else begin
			duty_reg[base] = '0;
			duty_reg[base + 1] = 15'(-d);
		end
		motor_rev[side] = want;
	endtask

	task automatic predict_drive_words(in_word_t w);
		int tilt_mag;
		int d_left;
		int d_right;
		bit stop;
		if (w.opcode == OP_MOTOR) begin
			tilt_mag = w.tilt_angle;
			if (tilt_mag < 0) tilt_mag = -tilt_mag;
			stop = tilt_mag > int'(tilt_lim);
			d_left = shaped_duty(w.left_command, dz_left, stop);
			d_right = shaped_duty(w.right_command, dz_right, stop);
			drive_side(1, d_right);
			drive_side(0, d_left);
			push_word(1'b0, 1'b1);
			motor_items++;
		end else begin
			speed_left = motor_rev[0] ? speed_left - w.left_count : speed_left + w.left_count;
			speed_right = motor_rev[1] ? speed_right - w.right_count : speed_right + w.right_count;
			tick_count = tick_count + 16'd1;
			if (tick_count >= tick_limit) begin
				tick_count = '0;
				sec_count = sec_count + 16'd1;
				if (sec_count == sec_wrap) sec_count = '0;
			end
			push_word(1'b0, 1'b1);
			encoder_items++;
		end
	endtask

	function automatic logic [15:0] pick_command();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 600)) - 300);
			2: return '0;
			3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'(int'($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int lim;
		w.opcode = $urandom_range(0, 1) ? OP_ENCODER : OP_MOTOR;
		w.left_command = pick_command();
		w.right_command = pick_command();
		lim = int'(tilt_lim);
		if ($urandom_range(0, 9) < 7) w.tilt_angle = 16'(int'($urandom_range(0, 2 * lim)) - lim);
		else w.tilt_angle = 16'($urandom);
		w.left_count = 8'($urandom);
		w.right_count = 8'($urandom);
		return w;
	endfunction

	function automatic in_word_t motor_word(int l, int r, int t);
		in_word_t w;
		w.opcode = OP_MOTOR;
		w.left_command = 16'(l);
		w.right_command = 16'(r);
		w.tilt_angle = 16'(t);
		w.left_count = 8'($urandom);
		w.right_count = 8'($urandom);
		return w;
	endfunction

	function automatic in_word_t encoder_word(int lc, int rc);
		in_word_t w;
		w.opcode = OP_ENCODER;
		w.left_command = 16'($urandom);
		w.right_command = 16'($urandom);
		w.tilt_angle = 16'($urandom);
		w.left_count = 8'(lc);
		w.right_count = 8'(rc);
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		predict_drive_words(w);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_words();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_drive_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		errors++;
		if (printed < MAX_PRINTED) begin
			printed++;
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		end
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want) report_mismatch(name, got, want);
	endtask

	task automatic test_default_drive();
		send_word(motor_word(100, 200, 0));
		send_word(encoder_word(255, 0));
		send_word(motor_word(-100, 50, 5));
		send_word(motor_word(-5, -7, -20));
		send_word(encoder_word(0, 255));
		send_word(motor_word(300, 400, 21));
		send_word(motor_word(32767, -32768, -20));
		send_word(motor_word(0, 0, -21));
		send_word(encoder_word(255, 255));
		drain_words();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_DEAD_ZONE_LEFT, 16'hFFFF);
		write_reg(CFG_DEAD_ZONE_RIGHT, 16'h3FFF);
		write_reg(CFG_DUTY_LIMIT, 16'hFFFF);
		write_reg(CFG_TILT_LIMIT, 16'hFFFF);
		write_reg(CFG_SPARE_LO, 16'h0000);
		write_reg(CFG_SPARE_HI, 16'h1234);
		send_word(motor_word(1, -1, -32768));
		send_word(motor_word(1, -1, 32767));
		send_word(motor_word(32767, -32768, 0));
		send_word(motor_word(-1, 1, 0));
		drain_words();
		write_reg(CFG_DUTY_LIMIT, 16'h0000);
		write_reg(CFG_TILT_LIMIT, 16'h0000);
		send_word(motor_word(-5, 5, 0));
		send_word(motor_word(10, 10, 1));
		drain_words();
		write_reg(CFG_DEAD_ZONE_LEFT, 16'd0);
		write_reg(CFG_DEAD_ZONE_RIGHT, 16'd0);
		write_reg(CFG_DUTY_LIMIT, 16'd32767);
		write_reg(CFG_TILT_LIMIT, 16'd20);
	endtask

	task automatic test_seconds_timer();
		write_reg(CFG_TICKS_PER_SECOND, 16'd1);
		write_reg(CFG_SECONDS_WRAP, 16'd3);
		repeat (4) send_word(encoder_word($urandom_range(0, 255), $urandom_range(0, 255)));
		drain_words();
		write_reg(CFG_SECONDS_WRAP, 16'd1);
		repeat (2) send_word(encoder_word($urandom_range(0, 255), $urandom_range(0, 255)));
		drain_words();
		write_reg(CFG_TICKS_PER_SECOND, 16'd0);
		repeat (2) send_word(encoder_word($urandom_range(0, 255), $urandom_range(0, 255)));
		drain_words();
		write_reg(CFG_TICKS_PER_SECOND, 16'hFFFF);
		write_reg(CFG_SECONDS_WRAP, 16'hFFFF);
		send_word(encoder_word(255, 255));
		drain_words();
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		burst_left = 0;
		receiver_hold = 80;
		repeat (30) send_word(random_word());
		gaps_on = 1'b1;
		drain_words();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_DEAD_ZONE_LEFT, 16'd0);
					write_reg(CFG_DEAD_ZONE_RIGHT, 16'd0);
					write_reg(CFG_DUTY_LIMIT, 16'd32767);
					write_reg(CFG_TILT_LIMIT, 16'd32767);
					write_reg(CFG_TICKS_PER_SECOND, 16'd1);
					write_reg(CFG_SECONDS_WRAP, 16'hFFFF);
				end
				1: begin
					write_reg(CFG_DEAD_ZONE_LEFT, 16'($urandom_range(0, 16383)));
					write_reg(CFG_DEAD_ZONE_RIGHT, 16'($urandom_range(0, 16383)));
					write_reg(CFG_DUTY_LIMIT, 16'($urandom_range(0, 32767)));
					write_reg(CFG_TILT_LIMIT, 16'($urandom_range(0, 200)));
					write_reg(CFG_TICKS_PER_SECOND, 16'($urandom_range(1, 8)));
					write_reg(CFG_SECONDS_WRAP, 16'($urandom_range(1, 10)));
				end
				2: begin
					write_reg(CFG_DEAD_ZONE_LEFT, 16'd16383);
					write_reg(CFG_DEAD_ZONE_RIGHT, 16'd16383);
					write_reg(CFG_DUTY_LIMIT, 16'd32767);
					write_reg(CFG_TILT_LIMIT, 16'd0);
					write_reg(CFG_TICKS_PER_SECOND, 16'd65535);
					write_reg(CFG_SECONDS_WRAP, 16'd1);
				end
				default: begin
					write_reg(CFG_DEAD_ZONE_LEFT, 16'($urandom_range(0, 600)));
					write_reg(CFG_DEAD_ZONE_RIGHT, 16'($urandom));
					write_reg(CFG_DUTY_LIMIT, 16'($urandom));
					write_reg(CFG_TILT_LIMIT, 16'($urandom));
					write_reg(CFG_TICKS_PER_SECOND, 16'($urandom_range(1, 4)));
					write_reg(CFG_SECONDS_WRAP, 16'($urandom_range(1, 6)));
				end
			endcase
			repeat (95) send_word(random_word());
			drain_words();
		end
	endtask

	always @(negedge clk) begin
		if (receiver_hold > 0) begin
			receiver_hold = receiver_hold - 1;
			out_ready <= 1'b0;
		end else begin
			if (ready_run_left == 0) begin
				ready_run_left = $urandom_range(5, 60);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 80;
				endcase
			end
			ready_run_left = ready_run_left - 1;
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_drive_words.size() == 0) begin
				report_mismatch("result word with none expected", 16'h0, 16'h0);
			end else begin
				front_word = expected_drive_words.pop_front();
				check_field("left_forward_duty", out_data.left_forward_duty,
					front_word.left_forward_duty);
				check_field("left_reverse_duty", out_data.left_reverse_duty,
					front_word.left_reverse_duty);
				check_field("right_forward_duty", out_data.right_forward_duty,
					front_word.right_forward_duty);
				check_field("right_reverse_duty", out_data.right_reverse_duty,
					front_word.right_reverse_duty);
				check_field("dead_time_hold", out_data.dead_time_hold, front_word.dead_time_hold);
				check_field("left_speed", out_data.left_speed, front_word.left_speed);
				check_field("right_speed", out_data.right_speed, front_word.right_speed);
				check_field("seconds", out_data.seconds, front_word.seconds);
				check_field("last", out_data.last, front_word.last);
				words_checked++;
				if (front_word.dead_time_hold) snapshots_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d result words outstanding",
				idle_cycles, expected_drive_words.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		reset_prediction();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_default_drive();
		test_register_extremes();
		test_seconds_timer();
		test_backpressure();
		test_random_traffic();
		drain_words();
		repeat (8) @(posedge clk);
		$display("covered %0d motor commands and %0d encoder samples over %0d register writes",
			motor_items, encoder_items, reg_writes);
		$display("checked %0d result words, %0d of them braked reversal snapshots",
			words_checked, snapshots_seen);
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
